FILE: design/mh64_pkg.sv
package mh64_pkg;

   // multiplier constant and shift of the hash
   localparam logic [63:0] MURMUR_M = 64'hc6a4a7935bd1e995;
   localparam int unsigned MURMUR_R = 47;

   localparam int unsigned LENGTH_BITS_DEFAULT = 32;

   // item operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_WORD  = 1'b1;

   // register file: one 64-bit register per 8 bytes
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam logic        CSR_IDX_SEED  = 1'b0;

   // source of the multiplier operand
   typedef enum logic [2:0] {
      OPND_LEN,
      OPND_WORD,
      OPND_MIX,
      OPND_HASH_MIX,
      OPND_TAIL,
      OPND_FIN
   } opnd_sel_type;

   typedef struct packed {
      logic         mul_start;
      opnd_sel_type opnd_sel;
      logic         rem_load;
      logic         rem_step;
      logic         rem_clear;
      logic         hash_seed_load;
      logic         hash_acc_load;
      logic         out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic rem_zero;
      logic rem_ge8;
   } dp_status_type;

endpackage

FILE: design/mh64_datapath.sv
module mh64_datapath #(
   parameter int unsigned LENGTH_BITS = mh64_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mh64_pkg::ctrl_cmd_type cmd,
   output mh64_pkg::dp_status_type status,
   input  logic [63:0]            seed,
   input  logic [31:0]            req_length,
   input  logic [63:0]            req_data_word,
   output logic [63:0]            rsp_hash_value
);

   localparam int unsigned LEN_IN_BITS = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

   // multiply sequencer phases: one 32x32 partial product per cycle
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LL,
      PH_LH,
      PH_HL,
      PH_ACC
   } phase_type;

   phase_type               phase_ff;
   logic                    done_ff;
   logic [63:0]             opnd_ff;
   logic [63:0]             prod_ff;
   logic [63:0]             acc_ff;
   logic [63:0]             hash_ff;
   logic [LENGTH_BITS-1:0]  rem_ff;
   logic [63:0]             rsp_hash_ff;

   logic [LENGTH_BITS-1:0]  len_value;
   logic [63:0]             len_wide;
   logic [63:0]             keep_mask;
   logic [63:0]             opnd_in;
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [63:0]             mul_p;

   assign len_value = LENGTH_BITS'(req_length[LEN_IN_BITS-1:0]);
   assign len_wide  = 64'(len_value);

   // bytes of the final word below length & 7
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         keep_mask[8*i +: 8] = (3'(i) < rem_ff[2:0]) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      unique case (cmd.opnd_sel)
         mh64_pkg::OPND_LEN:      opnd_in = len_wide;
         mh64_pkg::OPND_WORD:     opnd_in = req_data_word;
         mh64_pkg::OPND_MIX:      opnd_in = acc_ff ^ (acc_ff >> mh64_pkg::MURMUR_R);
         mh64_pkg::OPND_HASH_MIX: opnd_in = hash_ff ^ acc_ff;
         mh64_pkg::OPND_TAIL:     opnd_in = hash_ff ^ (req_data_word & keep_mask);
         mh64_pkg::OPND_FIN:      opnd_in = hash_ff ^ (hash_ff >> mh64_pkg::MURMUR_R);
         default:                 opnd_in = opnd_ff;
      endcase
   end

   // low 64 bits of opnd * M from three partial products
   assign mul_a = (phase_ff == PH_HL) ? opnd_ff[63:32] : opnd_ff[31:0];
   assign mul_b = (phase_ff == PH_LH) ? mh64_pkg::MURMUR_M[63:32]
                                      : mh64_pkg::MURMUR_M[31:0];
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            PH_IDLE: if (cmd.mul_start) phase_ff <= PH_LL;
            PH_LL:   phase_ff <= PH_LH;
            PH_LH:   phase_ff <= PH_HL;
            PH_HL:   phase_ff <= PH_ACC;
            PH_ACC: begin
               phase_ff <= PH_IDLE;
               done_ff  <= 1'b1;
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (phase_ff == PH_LH) begin
         acc_ff <= prod_ff;
      end else if (phase_ff == PH_HL || phase_ff == PH_ACC) begin
         acc_ff[63:32] <= acc_ff[63:32] + prod_ff[31:0];
      end
      if (cmd.mul_start) opnd_ff <= opnd_in;
      if (cmd.hash_seed_load) begin
         hash_ff <= seed ^ acc_ff;
      end else if (cmd.hash_acc_load) begin
         hash_ff <= acc_ff;
      end
      if (cmd.rem_load) begin
         rem_ff <= len_value;
      end else if (cmd.rem_step) begin
         rem_ff <= rem_ff - LENGTH_BITS'(8);
      end else if (cmd.rem_clear) begin
         rem_ff <= '0;
      end
      if (cmd.out_load) rsp_hash_ff <= acc_ff ^ (acc_ff >> mh64_pkg::MURMUR_R);
   end

   assign status.mul_done = done_ff;
   assign status.rem_zero = (rem_ff == '0);
   assign status.rem_ge8  = |rem_ff[LENGTH_BITS-1:3];
   assign rsp_hash_value  = rsp_hash_ff;

endmodule

FILE: design/mh64_control.sv
module mh64_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mh64_pkg::ctrl_cmd_type  cmd,
   input  mh64_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEN_WAIT,
      S_K1_WAIT,
      S_K2_WAIT,
      S_HASH_WAIT,
      S_FIN_LOAD,
      S_FIN_WAIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      active_ff, active_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.opnd_sel = mh64_pkg::OPND_LEN;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == mh64_pkg::OP_START) begin
                  cmd.mul_start = 1'b1;
                  cmd.opnd_sel  = mh64_pkg::OPND_LEN;
                  cmd.rem_load  = 1'b1;
                  active_in     = 1'b0;
                  state_in      = S_LEN_WAIT;
               end else if (active_ff) begin
                  cmd.mul_start = 1'b1;
                  if (status.rem_ge8) begin
                     cmd.opnd_sel = mh64_pkg::OPND_WORD;
                     cmd.rem_step = 1'b1;
                     state_in     = S_K1_WAIT;
                  end else begin
                     cmd.opnd_sel  = mh64_pkg::OPND_TAIL;
                     cmd.rem_clear = 1'b1;
                     state_in      = S_HASH_WAIT;
                  end
               end
            end
         end
         S_LEN_WAIT: begin
            if (status.mul_done) begin
               cmd.hash_seed_load = 1'b1;
               if (status.rem_zero) begin
                  state_in = S_FIN_LOAD;
               end else begin
                  active_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_K1_WAIT: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = mh64_pkg::OPND_MIX;
               state_in      = S_K2_WAIT;
            end
         end
         S_K2_WAIT: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = mh64_pkg::OPND_HASH_MIX;
               state_in      = S_HASH_WAIT;
            end
         end
         S_HASH_WAIT: begin
            if (status.mul_done) begin
               cmd.hash_acc_load = 1'b1;
               state_in = status.rem_zero ? S_FIN_LOAD : S_IDLE;
            end
         end
         S_FIN_LOAD: begin
            cmd.mul_start = 1'b1;
            cmd.opnd_sel  = mh64_pkg::OPND_FIN;
            state_in      = S_FIN_WAIT;
         end
         S_FIN_WAIT: begin
            if (status.mul_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               active_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/murmur64a_hash_stream.sv
// MurmurHash64A over a stream of 64-bit words. A start beat (operation 0)
// opens a message of req_length bytes and seeds the hash with
// seed ^ (length * M); each following word beat (operation 1) carries eight
// little-endian bytes, and the beat that completes the message returns the
// final hash on the rsp channel. A zero-length start returns its hash
// directly. Word beats outside a message are dropped, and a start during a
// message abandons it. All 64-bit products by M go through one shared
// 32x32 multiplier, three partial products per multiply. A start beat
// stalls the input for the length multiply, a full word beat for three
// multiplies, a partial word beat for one; the beat that ends a message,
// a zero-length start included, also stalls for the finalization
// multiply and the result hand-off, longer if the previous result has
// not been taken. An ignored word beat is taken without a stall. The seed
// register sits at byte address 0 of the csr port.
module murmur64a_hash_stream #(
   parameter int unsigned LENGTH_BITS = mh64_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input beats
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [31:0]                       req_length,
   input  logic [63:0]                       req_data_word,
   // result beats
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [63:0]                       rsp_hash_value,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mh64_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [63:0]                       pwdata,
   output logic [63:0]                       prdata,
   output logic                              pready
);

   mh64_pkg::ctrl_cmd_type  cmd;
   mh64_pkg::dp_status_type status;
   logic [63:0]             seed_ff;
   logic                    seed_sel;

   // register index sits above the 8-byte offset
   assign seed_sel = (paddr[mh64_pkg::CSR_ADDR_BITS-1] == mh64_pkg::CSR_IDX_SEED);
   assign pready   = 1'b1;
   assign prdata   = seed_sel ? seed_ff : 64'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'h0;
      end else if (psel && penable && pwrite && seed_sel) begin
         seed_ff <= pwdata;
      end
   end

   // sequencing: start, per-word mix, finalize, result hand-off
   mh64_control u_control (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   // hash, byte count, shared multiplier and result register
   mh64_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .seed           (seed_ff),
      .req_length     (req_length),
      .req_data_word  (req_data_word),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

FILE: design/mh64_checker.sv
module mh64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash_value
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result changed while stalled");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a start beat always keeps the block busy for the length multiply
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == mh64_pkg::OP_START |=> req_stall)
      else $error("start beat did not occupy the block");

   // a new result only comes out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

endmodule

bind murmur64a_hash_stream mh64_checker u_mh64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);

FILE: tb/tb_murmur64a_hash_stream.sv
`timescale 1ns / 100ps

module tb_murmur64a_hash_stream;

   localparam int unsigned ADDR_BITS = mh64_pkg::CSR_ADDR_BITS;
   // byte address of the seed register, one 64-bit register per 8 bytes
   localparam logic [ADDR_BITS-1:0] SEED_ADDR = ADDR_BITS'(8 * mh64_pkg::CSR_IDX_SEED);
   // idle odds in percent on each side
   localparam int unsigned IDLE_PCT = 38;
   // quiet cycles after the last hash, covers a word beat plus finalization
   localparam int unsigned SETTLE_CYCLES = 40;
   // length of the one long result hold-off
   localparam int unsigned HOLD_CYCLES = 400;

   // running hash of the open message and the queue of hashes still owed
   class hash_scoreboard;
      bit [63:0]   seed;
      bit [63:0]   running_hash;
      bit [31:0]   bytes_left;
      bit          in_message;
      bit [63:0]   pending_hashes[$];
      int unsigned mismatches;

      function bit [63:0] finalize_hash(bit [63:0] h);
         h = h ^ (h >> mh64_pkg::MURMUR_R);
         h = h * mh64_pkg::MURMUR_M;
         h = h ^ (h >> mh64_pkg::MURMUR_R);
         return h;
      endfunction

      function void note_beat(logic op, bit [31:0] len, bit [63:0] word);
         bit [63:0]   k;
         bit [63:0]   keep;
         int unsigned n;
         if (op == mh64_pkg::OP_START) begin
            // a start always reseeds, abandoning any open message
            running_hash = seed ^ (64'(len) * mh64_pkg::MURMUR_M);
            bytes_left   = len;
            in_message   = (len != 0);
            if (len == 0)
               pending_hashes.push_back(finalize_hash(running_hash));
         end else if (in_message) begin
            if (bytes_left >= 8) begin
               k = word * mh64_pkg::MURMUR_M;
               k = k ^ (k >> mh64_pkg::MURMUR_R);
               k = k * mh64_pkg::MURMUR_M;
               running_hash = (running_hash ^ k) * mh64_pkg::MURMUR_M;
               bytes_left   = bytes_left - 8;
            end else begin
               // tail word: only the low bytes still owed count
               n            = bytes_left[2:0];
               keep         = (64'd1 << (8 * n)) - 64'd1;
               running_hash = (running_hash ^ (word & keep)) * mh64_pkg::MURMUR_M;
               bytes_left   = 0;
            end
            if (bytes_left == 0) begin
               in_message = 1'b0;
               pending_hashes.push_back(finalize_hash(running_hash));
            end
         end
      endfunction

      function void check_hash(bit [63:0] got);
         bit [63:0] exp_hash;
         if (pending_hashes.size() == 0) begin
            $error("unexpected rsp beat, hash_value %h", got);
            mismatches++;
         end else begin
            exp_hash = pending_hashes.pop_front();
            if (exp_hash != got) begin
               $error("hash_value mismatch: expected %h, actual %h", exp_hash, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // input beat channel
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_operation = mh64_pkg::OP_START;
   logic [31:0] req_length    = '0;
   logic [63:0] req_data_word = '0;

   // result beat channel
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [63:0] rsp_hash_value;

   // register port
   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [ADDR_BITS-1:0] paddr   = '0;
   logic [63:0]          pwdata  = '0;
   logic [63:0]          prdata;
   logic                 pready;

   hash_scoreboard sb;

   // steady: no idling on either side; hold_go: request the long hold-off
   bit          steady    = 1'b0;
   bit          hold_go   = 1'b0;
   bit          hold_used = 1'b0;
   int unsigned hold_left = 0;
   int unsigned beats_sent = 0;

   always #10 clock = ~clock;

   murmur64a_hash_stream DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_length     (req_length),
      .req_data_word  (req_data_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // result side: check every accepted beat, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_hash(rsp_hash_value);
      // one long hold-off, counted here, lets the block back up into req
      if (hold_go && !hold_used) begin
         hold_left = HOLD_CYCLES;
         hold_used = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // message data, biased toward all-zero and all-one words
   function automatic bit [63:0] rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // offer one beat, after a random gap unless steady, and hold it until it is taken
   task automatic send_beat(input logic op, input bit [31:0] len, input bit [63:0] word);
      bit counts;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_length    <= len;
      req_data_word <= word;
      do @(posedge clock); while (!(req_valid && !req_stall));
      // word beats outside a message are dropped and not counted
      counts = (op == mh64_pkg::OP_START) || sb.in_message;
      sb.note_beat(op, len, word);
      if (counts)
         beats_sent++;
   endtask

   // a start followed by some words of random content
   task automatic send_message(input bit [31:0] len, input int unsigned word_count);
      send_beat(mh64_pkg::OP_START, len, rand_word());
      repeat (word_count)
         send_beat(mh64_pkg::OP_WORD, $urandom, rand_word());
   endtask

   // setup phase, then access phase, then the bus goes idle before returning
   task automatic write_seed(input bit [63:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= SEED_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.seed = value;
      @(posedge clock);
   endtask

   task automatic check_seed_readback();
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      paddr   <= SEED_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata != sb.seed) begin
         $error("seed mismatch: expected %h, actual %h", sb.seed, prdata);
         sb.mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // let every owed hash arrive, then let any dropped work finish
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_hashes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random mix: mostly whole messages, some abandoned ones and stray words
   task automatic run_random(input int unsigned beat_goal);
      int unsigned first;
      int unsigned pick;
      int unsigned len;
      first = beats_sent;
      while (beats_sent - first < beat_goal) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            // stray word, dropped when no message is open
            send_beat(mh64_pkg::OP_WORD, $urandom, rand_word());
         end else if (pick < 12) begin
            // huge length, cut short by the next start
            send_message($urandom, $urandom_range(3));
         end else if (pick < 17) begin
            // ordinary message cut short
            len = $urandom_range(9, 64);
            send_message(len, $urandom_range((len + 7) / 8 - 1));
         end else begin
            pick = $urandom_range(99);
            if (pick < 60)
               len = $urandom_range(24);
            else if (pick < 90)
               len = $urandom_range(25, 64);
            else
               len = $urandom_range(65, 200);
            send_message(len, (len + 7) / 8);
         end
      end
      // empty message leaves the block idle for the next register write
      send_beat(mh64_pkg::OP_START, 32'd0, rand_word());
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seed comes out of reset as zero
      check_seed_readback();

      // directed: stray words, empty message, every tail size class,
      // unused tail bytes set, maximum length abandoned by a new start
      send_beat(mh64_pkg::OP_WORD, 32'hffff_ffff, '1);
      send_beat(mh64_pkg::OP_START, 32'd0, '1);
      send_beat(mh64_pkg::OP_START, 32'd1, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_START, 32'd7, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_START, 32'd8, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_START, 32'd9, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_START, 32'hffff_ffff, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '0);
      send_beat(mh64_pkg::OP_START, 32'd16, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, rand_word());
      send_beat(mh64_pkg::OP_WORD, 32'd0, rand_word());
      send_beat(mh64_pkg::OP_WORD, 32'd0, '0);
      send_beat(mh64_pkg::OP_START, 32'd15, '0);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '1);
      send_beat(mh64_pkg::OP_START, 32'd2, '1);
      send_beat(mh64_pkg::OP_WORD, 32'd0, '0);
      send_beat(mh64_pkg::OP_START, 32'd0, '0);
      drain();

      // all-ones seed, first stretch with no idling at all
      write_seed('1);
      check_seed_readback();
      steady <= 1'b1;
      run_random(200);
      steady <= 1'b0;
      run_random(300);
      drain();

      // random seed, with the long result hold-off under load
      write_seed({$urandom, $urandom});
      check_seed_readback();
      hold_go <= 1'b1;
      run_random(500);
      drain();

      // top and bottom seed bits only
      write_seed(64'h8000_0000_0000_0001);
      check_seed_readback();
      run_random(500);
      drain();

      if (sb.mismatches == 0)
         $display("PASS murmur64a_hash_stream");
      else
         $display("FAIL murmur64a_hash_stream");
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #10_000_000;
      $display("FAIL murmur64a_hash_stream");
      $finish;
   end

endmodule
